/* hw/rtl/lss_pkg.sv */
// Shared types, codes and helpers for the line substring search unit.
package lss_pkg;

    // Input word action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TEXT = 2'd1;
    localparam logic [1:0] ACT_EOF  = 2'd2;

    // Result word kinds
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register select (paddr[2])
    localparam logic REG_PATTERN_LENGTH   = 1'b0;
    localparam logic REG_CASE_INSENSITIVE = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic        kind;
        logic [23:0] line_number;
        logic [7:0]  line_length;
        logic [23:0] hit_count;
        logic        last;
    } result_t;

    // Per-cycle control broadcast along the cell chain
    typedef struct packed {
        logic shift;
        logic clear;
        logic fold;
    } cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold);
        if (fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/lss_cell.sv */
// One pattern position: holds a pattern byte and its partial-match bit.
module lss_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  lss_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         text_folded,
    input  logic               wr_en,
    input  logic [7:0]         wr_data,
    input  logic               prev_match,
    output logic               match,
    output logic               match_next
);
    import lss_pkg::*;

    logic [7:0] pattern_reg;
    logic       match_reg;

    // shift-and step: extend the neighbor's partial match by this byte
    assign match_next = prev_match && (fold_byte(pattern_reg, ctrl.fold) == text_folded);
    assign match      = match_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pattern_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.clear) begin
            match_reg <= 1'b0;
        end else if (ctrl.shift) begin
            match_reg <= match_next;
        end
    end

endmodule

/* hw/rtl/lss_result_fifo.sv */
// Small result queue taking up to two words per cycle, one out per cycle.
module lss_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  lss_pkg::result_t push_a,
    input  lss_pkg::result_t push_b,
    output logic             room2,
    output logic             out_valid,
    input  logic             out_ready,
    output lss_pkg::result_t out_word
);
    import lss_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/line_substring_search_unit.sv */
// Top level: line-oriented substring search over a byte stream.
//
// Usage:
//   s_ channel takes one word per cycle while s_ready is high: action 0
//   loads pattern byte s_byte_value at s_pattern_index, action 1 feeds a
//   text byte, action 2 marks end of file. Action 3 is dropped.
//   m_ channel returns result words: a line report (kind 0) for every line
//   that contains the pattern, and a summary (kind 1) with the hit count at
//   end of file. m_last flags the final word caused by one input word.
//   The APB port holds pattern_length (0x0) and case_insensitive (0x4);
//   write them only while the block is idle.
// Throughput: one input word per cycle while s_ready is high. The
//   shift-and chain of cells updates all pattern positions in parallel
//   for each text byte, so a text byte never waits on the pattern length.
// Results: a result word is registered into the queue when the closing
//   input word is accepted and reaches m_ after the words ahead of it.
// Stall: results go to a four-word queue; s_ready drops while fewer than two
//   slots are free, since one word can cause two results.
// Reset: clears counters, partial matches, queue and registers. The pattern
//   bytes are not cleared and must be loaded before use.
module line_substring_search_unit #(
    parameter int LINE_MAX    = 256,
    parameter int PATTERN_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_pattern_index,
    input  logic [7:0]  s_byte_value,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [23:0] m_line_number,
    output logic [7:0]  m_line_length,
    output logic [23:0] m_hit_count,
    output logic        m_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lss_pkg::*;

    localparam int CW = $clog2(LINE_MAX);
    localparam int UW = $clog2(PATTERN_MAX + 1);

    // ---------------- configuration ----------------
    logic [6:0] cfg_plen_reg;
    logic       cfg_ci_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_plen_reg <= '0;
            cfg_ci_reg   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PATTERN_LENGTH:   cfg_plen_reg <= pwdata[6:0];
                REG_CASE_INSENSITIVE: cfg_ci_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PATTERN_LENGTH:   prdata = {25'd0, cfg_plen_reg};
            REG_CASE_INSENSITIVE: prdata = {31'd0, cfg_ci_reg};
            default:              prdata = '0;
        endcase
    end

    // pattern length clamped to the chain length
    logic [UW-1:0] used_len;
    always_comb begin
        if (int'(cfg_plen_reg) > PATTERN_MAX) begin
            used_len = UW'(PATTERN_MAX);
        end else begin
            used_len = UW'(cfg_plen_reg);
        end
    end

    // ---------------- input decode ----------------
    logic s_fire, is_load, is_text, is_eof, is_lf, is_cr, do_shift;
    logic [7:0] text_folded;

    assign s_fire   = s_valid && s_ready;
    assign is_load  = s_fire && (s_action == ACT_LOAD);
    assign is_text  = s_fire && (s_action == ACT_TEXT);
    assign is_eof   = s_fire && (s_action == ACT_EOF);
    assign is_lf    = (s_byte_value == CHAR_LF);
    assign is_cr    = (s_byte_value == CHAR_CR);
    assign do_shift = is_text && !is_lf && !is_cr;
    assign text_folded = fold_byte(s_byte_value, cfg_ci_reg);

    // ---------------- cell chain ----------------
    cell_ctrl_t             cell_ctrl;
    logic [PATTERN_MAX-1:0] match, match_next, prev_match, tail;
    logic                   close_now;

    assign cell_ctrl.shift = do_shift;
    assign cell_ctrl.clear = close_now || is_eof;
    assign cell_ctrl.fold  = cfg_ci_reg;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign prev_match[j] = 1'b1;
        end else begin : g_link
            assign prev_match[j] = match[j-1];
        end
        // this cell ends the pattern in use
        assign tail[j] = (used_len == UW'(j + 1));

        lss_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .text_folded (text_folded),
            .wr_en       (is_load && (int'(s_pattern_index) == j)),
            .wr_data     (s_byte_value),
            .prev_match  (prev_match[j]),
            .match       (match[j]),
            .match_next  (match_next[j])
        );
    end

    // ---------------- line tracking ----------------
    logic [CW-1:0] column_reg, column_next, col_inc;
    logic          line_hit_reg, line_hit_next;
    logic          line_open_reg, line_open_next;
    logic [23:0]   line_count_reg, line_count_next, lc_inc;
    logic [23:0]   hits_reg, hits_next, hits_inc;
    logic          byte_hit, hit_now, line_full, report;
    logic [CW-1:0] len_out;

    assign byte_hit  = |(match_next & tail);
    assign col_inc   = column_reg + CW'(1);
    assign line_full = do_shift && (col_inc == CW'(LINE_MAX - 1));
    assign close_now = (is_text && is_lf) || line_full || (is_eof && line_open_reg);
    assign hit_now   = line_hit_reg || (do_shift && byte_hit);
    // empty pattern matches every line
    assign report    = close_now && (hit_now || (used_len == '0));
    assign lc_inc    = (line_count_reg == COUNT_MAX) ? COUNT_MAX : line_count_reg + 24'd1;
    assign hits_inc  = (report && hits_reg != COUNT_MAX) ? hits_reg + 24'd1 : hits_reg;
    assign len_out   = do_shift ? col_inc : column_reg;

    always_comb begin
        column_next     = column_reg;
        line_hit_next   = line_hit_reg;
        line_open_next  = line_open_reg;
        line_count_next = line_count_reg;
        hits_next       = hits_reg;
        if (do_shift) begin
            column_next   = col_inc;
            line_hit_next = hit_now;
        end
        if (is_text) begin
            line_open_next = 1'b1;   // CR opens a line too
        end
        if (close_now) begin
            line_count_next = lc_inc;
            hits_next       = hits_inc;
            column_next     = '0;
            line_hit_next   = 1'b0;
            line_open_next  = 1'b0;
        end
        if (is_eof) begin
            line_count_next = '0;
            hits_next       = '0;
            column_next     = '0;
            line_hit_next   = 1'b0;
            line_open_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            line_hit_reg   <= 1'b0;
            line_open_reg  <= 1'b0;
            line_count_reg <= '0;
            hits_reg       <= '0;
        end else begin
            column_reg     <= column_next;
            line_hit_reg   <= line_hit_next;
            line_open_reg  <= line_open_next;
            line_count_reg <= line_count_next;
            hits_reg       <= hits_next;
        end
    end

    // ---------------- result words ----------------
    result_t    word_report, word_summary, push_a, push_b, out_word;
    logic [1:0] push_cnt;
    logic       room2;

    always_comb begin
        word_report.kind         = KIND_LINE;
        word_report.line_number  = lc_inc;
        word_report.line_length  = 8'(len_out);
        word_report.hit_count    = '0;
        word_report.last         = !is_eof;   // summary follows at end of file

        word_summary.kind        = KIND_SUMMARY;
        word_summary.line_number = '0;
        word_summary.line_length = '0;
        word_summary.hit_count   = hits_inc;
        word_summary.last        = 1'b1;

        push_b   = word_summary;
        push_a   = word_report;
        push_cnt = 2'd0;
        priority if (report && is_eof) begin
            push_cnt = 2'd2;
        end else if (report) begin
            push_cnt = 2'd1;
        end else if (is_eof) begin
            push_a   = word_summary;
            push_cnt = 2'd1;
        end
    end

    lss_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_a    (push_a),
        .push_b    (push_b),
        .room2     (room2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign s_ready       = room2;
    assign m_kind        = out_word.kind;
    assign m_line_number = out_word.line_number;
    assign m_line_length = out_word.line_length;
    assign m_hit_count   = out_word.hit_count;
    assign m_last        = out_word.last;

endmodule
